// ===== rtl/cwk_pkg.sv =====
`default_nettype none

package cwk_pkg;

    // fixed widths of the register file
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int HOLD_TICKS_WIDTH = 16;

    // default hold counter width
    localparam int HOLD_COUNT_WIDTH_DEFAULT = 16;

    // reset value of the hold period
    localparam logic [HOLD_TICKS_WIDTH-1:0] HOLD_TICKS_RESET = 16'd1000;

    // register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SEMI_BREAKIN  = 2'd0,
        CFG_HOST_SELECT   = 2'd1,
        CFG_EXT_SOUND     = 2'd2,
        CFG_HOLD_TICKS    = 2'd3
    } cfg_index_t;

    // host signalling codes
    localparam logic [1:0] HOST_NONE = 2'd0;
    localparam logic [1:0] HOST_ATU  = 2'd1;
    localparam logic [1:0] HOST_AMP  = 2'd2;

    // configuration as seen by the control logic
    typedef struct packed {
        logic                        semi_breakin_on;
        logic [1:0]                  host_signal_select;
        logic                        external_sound_on;
        logic [HOLD_TICKS_WIDTH-1:0] hold_ticks;
    } cwk_cfg_t;

    // input beat
    typedef struct packed {
        logic paddle_a_level;
        logic paddle_b_level;
        logic host_request;
        logic timer_tick;
    } cwk_in_t;

    // result beat
    typedef struct packed {
        logic tx_line;
        logic sidetone_line;
        logic atu_request;
        logic atu_request_enable;
        logic amp_line_n;
    } cwk_out_t;

    // status from the control logic
    typedef struct packed {
        logic atu_enable;
        logic hold_expired;
        logic hold_zero;
    } cwk_status_t;

endpackage

`default_nettype wire

// ===== rtl/cw_keying_semi_breakin_control_core.sv =====
// Morse key transmit controller, one poll per input beat.
// Input channel (in_valid / in_stall / in_data) carries the paddle levels,
// the host transmit request and the hold-timer tick of one poll. The output
// channel (out_valid / out_stall / out_data) returns one beat per poll with
// the TX, sidetone, ATU request, ATU enable and amplifier line states after
// that poll. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must write it only while the block is idle, which the block does not enforce.
// A beat accepted into the input register is processed from there and its
// result is registered in the result register, which drives out_valid.
// Throughput: one beat per cycle while the output is not stalled; the input
// register feeds the step logic and the result register in a single pass.
// A stall on the output holds the result register; the input register then
// fills and in_stall rises in the same cycle, so no beat is lost.
// Reset clears both pipeline stages, sets normal keying mode, a hold period
// of 1000 ticks, all lines off (amplifier line high) and the hold timer
// expired.
`default_nettype none

module cw_keying_semi_breakin_control_core #(
    parameter int HOLD_COUNT_WIDTH = cwk_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire cwk_pkg::cwk_in_t                     in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output cwk_pkg::cwk_out_t                         out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [cwk_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [cwk_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import cwk_pkg::*;

    cwk_cfg_t    cfg;
    cwk_status_t status;
    cwk_out_t    result_next;

    logic        s1_valid_reg;
    cwk_in_t     s1_data_reg;
    logic        out_valid_reg;
    cwk_out_t    out_data_reg;
    logic        advance;
    logic        fire;

    // configuration registers
    cwk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // keying state and step logic
    cwk_ctrl #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .item        (s1_data_reg),
        .result_next (result_next),
        .status      (status)
    );

    // pipeline flow control
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // beat payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_data_reg <= in_data;
        if (fire)
            out_data_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // input only stalls with both stages full and the output held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stall without a full pipeline");

    // atu enable is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        status.atu_enable |=> status.atu_enable)
        else $error("atu enable cleared");

    // an expired hold timer always sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        status.hold_expired |-> status.hold_zero)
        else $error("hold timer expired with nonzero count");

    // a fired beat lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed beat missing from output");

endmodule

`default_nettype wire

// ===== rtl/cwk_cfg_regs.sv =====
`default_nettype none

module cwk_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [cwk_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [cwk_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output cwk_pkg::cwk_cfg_t                         cfg
);
    import cwk_pkg::*;

    cwk_cfg_t cfg_reg;

    // register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.semi_breakin_on    <= 1'b0;
            cfg_reg.host_signal_select <= HOST_NONE;
            cfg_reg.external_sound_on  <= 1'b0;
            cfg_reg.hold_ticks         <= HOLD_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SEMI_BREAKIN: cfg_reg.semi_breakin_on    <= cfg_data[0];
                CFG_HOST_SELECT:  cfg_reg.host_signal_select <= cfg_data[1:0];
                CFG_EXT_SOUND:    cfg_reg.external_sound_on  <= cfg_data[0];
                CFG_HOLD_TICKS:   cfg_reg.hold_ticks         <= cfg_data[HOLD_TICKS_WIDTH-1:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/cwk_ctrl.sv =====
`default_nettype none

module cwk_ctrl #(
    parameter int HOLD_COUNT_WIDTH = cwk_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cwk_pkg::cwk_cfg_t cfg,
    input  wire logic            fire,
    input  wire cwk_pkg::cwk_in_t  item,
    output cwk_pkg::cwk_out_t    result_next,
    output cwk_pkg::cwk_status_t status
);
    import cwk_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_CHECK_REQ  = 2'd1,
        PH_CHECK_UP   = 2'd2,
        PH_CHECK_HOLD = 2'd3
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        keyed_reg, keyed_next;
    logic [HOLD_COUNT_WIDTH-1:0] count_reg, count_next;
    logic                        expired_reg, expired_next;
    logic                        tx_reg, tx_next;
    logic                        side_reg, side_next;
    logic                        atu_reg, atu_next;
    logic                        atu_en_reg, atu_en_next;
    logic                        amp_reg, amp_next;

    logic                        pressed;
    logic [HOLD_COUNT_WIDTH-1:0] load_value;

    assign pressed    = !item.paddle_a_level || !item.paddle_b_level;
    assign load_value = HOLD_COUNT_WIDTH'(cfg.hold_ticks);

    // one step of the keying control
    always_comb
    begin
        phase_next   = phase_reg;
        keyed_next   = keyed_reg;
        count_next   = count_reg;
        expired_next = expired_reg;
        tx_next      = tx_reg;
        side_next    = side_reg;
        atu_next     = atu_reg;
        atu_en_next  = atu_en_reg;
        amp_next     = amp_reg;

        // hold timer runs first, stops at zero
        if (item.timer_tick)
        begin
            if (count_reg <= HOLD_COUNT_WIDTH'(1))
            begin
                count_next   = '0;
                expired_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - HOLD_COUNT_WIDTH'(1);
            end
        end

        if (cfg.semi_breakin_on)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (pressed)
                    begin
                        if (cfg.host_signal_select == HOST_ATU)
                        begin
                            atu_next    = 1'b1;
                            atu_en_next = 1'b1;
                        end
                        else if (cfg.host_signal_select == HOST_AMP)
                        begin
                            amp_next = 1'b0;
                        end
                        count_next   = load_value;
                        expired_next = 1'b0;
                        phase_next   = PH_CHECK_REQ;
                    end
                end
                PH_CHECK_REQ:
                begin
                    if (item.host_request)
                    begin
                        if (pressed)
                        begin
                            count_next   = load_value;
                            expired_next = 1'b0;
                            tx_next      = 1'b1;
                            if (cfg.external_sound_on)
                                side_next = 1'b1;
                        end
                        phase_next = PH_CHECK_UP;
                    end
                    else
                    begin
                        phase_next = PH_CHECK_HOLD;
                    end
                end
                PH_CHECK_UP:
                begin
                    if (!pressed)
                    begin
                        tx_next = 1'b0;
                        if (cfg.external_sound_on)
                            side_next = 1'b0;
                    end
                    phase_next = PH_CHECK_HOLD;
                end
                PH_CHECK_HOLD:
                begin
                    // timer already updated for this poll
                    if (expired_next)
                    begin
                        if (cfg.host_signal_select == HOST_ATU)
                            atu_next = 1'b0;
                        else if (cfg.host_signal_select == HOST_AMP)
                            amp_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_CHECK_REQ;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (item.host_request)
        begin
            // straight keying
            if (!pressed && keyed_reg)
            begin
                keyed_next = 1'b0;
                tx_next    = 1'b0;
                if (cfg.external_sound_on)
                    side_next = 1'b0;
            end
            else if (pressed && !keyed_reg)
            begin
                keyed_next = 1'b1;
                tx_next    = 1'b1;
                if (cfg.external_sound_on)
                    side_next = 1'b1;
            end
        end
    end

    // state update, one step per fired beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            keyed_reg   <= 1'b0;
            count_reg   <= '0;
            expired_reg <= 1'b1;
            tx_reg      <= 1'b0;
            side_reg    <= 1'b0;
            atu_reg     <= 1'b0;
            atu_en_reg  <= 1'b0;
            amp_reg     <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            keyed_reg   <= keyed_next;
            count_reg   <= count_next;
            expired_reg <= expired_next;
            tx_reg      <= tx_next;
            side_reg    <= side_next;
            atu_reg     <= atu_next;
            atu_en_reg  <= atu_en_next;
            amp_reg     <= amp_next;
        end
    end

    // result is the line state after the step
    always_comb
    begin
        result_next.tx_line            = tx_next;
        result_next.sidetone_line      = side_next;
        result_next.atu_request        = atu_next;
        result_next.atu_request_enable = atu_en_next;
        result_next.amp_line_n         = amp_next;
    end

    assign status.atu_enable   = atu_en_reg;
    assign status.hold_expired = expired_reg;
    assign status.hold_zero    = (count_reg == '0);

endmodule

`default_nettype wire

// ===== test/cw_keying_semi_breakin_control_core_test.sv =====
`default_nettype none

module cw_keying_semi_breakin_control_core_test;
    import cwk_pkg::*;

    localparam int HCW        = HOLD_COUNT_WIDTH_DEFAULT;
    localparam int HALF       = 6;
    localparam int RUN_LIMIT  = 12 * 300000;
    localparam int PHASES     = 13;
    localparam int PER_PHASE  = 50;

    // break-in machine phases
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_CHECK_REQ  = 2'd1,
        PH_CHECK_UP   = 2'd2,
        PH_CHECK_HOLD = 2'd3
    } breakin_phase_t;

    // one row of the directed table: a register write or a poll beat
    typedef struct {
        bit                         is_write;
        cfg_index_t                 idx;
        logic [CFG_DATA_WIDTH-1:0]  data;
        cwk_in_t                    beat;
        bit                         has_lit;
        cwk_out_t                   lit;
    } poll_row_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    cwk_in_t                    in_data   = '1;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    cwk_out_t                   out_data;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    cwk_out_t  expected_lines[$];
    poll_row_t poll_rows[$];
    int        mismatch_count = 0;
    bit        calm = 1'b0;
    bit        key_down = 1'b0;
    cwk_out_t  oldest;

    // predictor copy of configuration and state
    logic                        k_semi;
    logic [1:0]                  k_host;
    logic                        k_ext;
    logic [HOLD_TICKS_WIDTH-1:0] k_hold;
    breakin_phase_t              k_phase;
    logic                        k_keyed;
    logic [HCW-1:0]              k_count;
    logic                        k_expired;
    logic                        k_tx;
    logic                        k_side;
    logic                        k_atu;
    logic                        k_atu_en;
    logic                        k_amp;

    cw_keying_semi_breakin_control_core #(
        .HOLD_COUNT_WIDTH (HCW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #HALF;
        clk = 1'b1;
        #HALF;
    end

    // run limit
    initial
    begin
        #RUN_LIMIT;
        $display("cw_keying_semi_breakin_control_core_test failed");
        $finish;
    end

    // keyer state after reset
    task automatic clear_keyer();
        k_semi    = 1'b0;
        k_host    = HOST_NONE;
        k_ext     = 1'b0;
        k_hold    = HOLD_TICKS_RESET;
        k_phase   = PH_IDLE;
        k_keyed   = 1'b0;
        k_count   = '0;
        k_expired = 1'b1;
        k_tx      = 1'b0;
        k_side    = 1'b0;
        k_atu     = 1'b0;
        k_atu_en  = 1'b0;
        k_amp     = 1'b1;
    endtask

    // tx follows the key, and sidetone with it when external sound is on
    function automatic void drive_key(input logic on);
        k_tx = on;
        if (k_ext)
            k_side = on;
    endfunction

    function automatic void restart_hold();
        k_count   = HCW'(k_hold);
        k_expired = 1'b0;
    endfunction

    // one poll: hold timer first, then the active mode
    function automatic cwk_out_t predict_lines(input cwk_in_t b);
        logic     pressed;
        cwk_out_t r;
        pressed = !b.paddle_a_level || !b.paddle_b_level;
        if (b.timer_tick)
        begin
            if (k_count <= 1)
            begin
                k_count   = '0;
                k_expired = 1'b1;
            end
            else
                k_count = k_count - 1'b1;
        end
        if (k_semi)
        begin
            case (k_phase)
                PH_IDLE:
                begin
                    if (pressed)
                    begin
                        if (k_host == HOST_ATU)
                        begin
                            k_atu    = 1'b1;
                            k_atu_en = 1'b1;
                        end
                        else if (k_host == HOST_AMP)
                            k_amp = 1'b0;
                        restart_hold();
                        k_phase = PH_CHECK_REQ;
                    end
                end
                PH_CHECK_REQ:
                begin
                    if (b.host_request)
                    begin
                        if (pressed)
                        begin
                            restart_hold();
                            drive_key(1'b1);
                        end
                        k_phase = PH_CHECK_UP;
                    end
                    else
                        k_phase = PH_CHECK_HOLD;
                end
                PH_CHECK_UP:
                begin
                    if (!pressed)
                        drive_key(1'b0);
                    k_phase = PH_CHECK_HOLD;
                end
                default:
                begin
                    if (k_expired)
                    begin
                        if (k_host == HOST_ATU)
                            k_atu = 1'b0;
                        else if (k_host == HOST_AMP)
                            k_amp = 1'b1;
                        k_phase = PH_IDLE;
                    end
                    else
                        k_phase = PH_CHECK_REQ;
                end
            endcase
        end
        else if (b.host_request)
        begin
            if (!pressed && k_keyed)
            begin
                k_keyed = 1'b0;
                drive_key(1'b0);
            end
            else if (pressed && !k_keyed)
            begin
                k_keyed = 1'b1;
                drive_key(1'b1);
            end
        end
        r.tx_line            = k_tx;
        r.sidetone_line      = k_side;
        r.atu_request        = k_atu;
        r.atu_request_enable = k_atu_en;
        r.amp_line_n         = k_amp;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [4:0] got,
                                   input logic [4:0] want);
        $display("mismatch at %0t: %s got %b expected %b", $time, what, got, want);
        mismatch_count++;
    endtask

    // result side: check each beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lines.size() == 0)
                report_mismatch("beat with nothing expected", out_data, '0);
            else
            begin
                oldest = expected_lines.pop_front();
                // lines in order tx, sidetone, atu, atu enable, amp_n
                if (out_data !== oldest)
                    report_mismatch("result lines", out_data, oldest);
            end
        end
        out_stall <= !calm && ($urandom_range(99) < 23);
    end

    // offer one poll beat, with random gaps ahead of it
    task automatic send_beat(input cwk_in_t b);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
    endtask

    // register write, only once every result is back
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        drain_results();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SEMI_BREAKIN: k_semi = data[0];
            CFG_HOST_SELECT:  k_host = data[1:0];
            CFG_EXT_SOUND:    k_ext  = data[0];
            default:          k_hold = data[HOLD_TICKS_WIDTH-1:0];
        endcase
    endtask

    task automatic poll_and_check(input cwk_in_t b, input bit has_lit, input cwk_out_t lit);
        cwk_out_t pred;
        send_beat(b);
        pred = predict_lines(b);
        expected_lines.push_back(has_lit ? lit : pred);
    endtask

    function automatic void add_write(input cfg_index_t idx,
                                      input logic [CFG_DATA_WIDTH-1:0] data);
        poll_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        r.beat     = '0;
        r.has_lit  = 1'b0;
        r.lit      = '0;
        poll_rows.push_back(r);
    endfunction

    // beat fields in order a, b, request, tick; lit as {tx, side, atu, atu_en, amp_n}
    function automatic void add_beat(input logic [3:0] fields, input bit has_lit,
                                     input logic [4:0] lit);
        poll_row_t r;
        r.is_write = 1'b0;
        r.idx      = CFG_SEMI_BREAKIN;
        r.data     = '0;
        r.beat     = cwk_in_t'(fields);
        r.has_lit  = has_lit;
        r.lit      = cwk_out_t'(lit);
        poll_rows.push_back(r);
    endfunction

    // key-down runs with random paddles, plus some noise
    function automatic cwk_in_t random_beat();
        cwk_in_t b;
        if ($urandom_range(99) < 10)
            return cwk_in_t'(4'($urandom_range(15)));
        if ($urandom_range(99) < 30)
            key_down = !key_down;
        if (key_down)
            case ($urandom_range(2))
                0:       {b.paddle_a_level, b.paddle_b_level} = 2'b01;
                1:       {b.paddle_a_level, b.paddle_b_level} = 2'b10;
                default: {b.paddle_a_level, b.paddle_b_level} = 2'b00;
            endcase
        else
            {b.paddle_a_level, b.paddle_b_level} = 2'b11;
        b.host_request = ($urandom_range(99) < 75);
        b.timer_tick   = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic void build_directed();
        // normal keying straight after reset, hold period 1000
        add_beat(4'b1100, 1, 5'b00001);
        add_beat(4'b0100, 1, 5'b00001);   // no request, nothing moves
        add_beat(4'b0110, 1, 5'b10001);
        add_beat(4'b1111, 1, 5'b00001);
        add_write(CFG_EXT_SOUND, 16'd1);
        add_beat(4'b1010, 1, 5'b11001);
        add_beat(4'b1110, 1, 5'b00001);
        // semi break-in on the atu line, short hold
        add_write(CFG_SEMI_BREAKIN, 16'd1);
        add_write(CFG_HOST_SELECT, CFG_DATA_WIDTH'(HOST_ATU));
        add_write(CFG_HOLD_TICKS, 16'd2);
        add_beat(4'b0100, 1, 5'b00111);
        add_beat(4'b0110, 1, 5'b11111);
        add_beat(4'b1101, 1, 5'b00111);
        add_beat(4'b1101, 1, 5'b00011);
        // amplifier line with a zero hold period
        add_write(CFG_HOST_SELECT, CFG_DATA_WIDTH'(HOST_AMP));
        add_write(CFG_HOLD_TICKS, 16'd0);
        add_beat(4'b0010, 1, 5'b00010);
        add_beat(4'b0010, 1, 5'b11010);
        add_beat(4'b0011, 0, '0);
        add_beat(4'b1110, 0, '0);
        // unused host code, longest hold, sidetone off
        add_write(CFG_HOST_SELECT, 16'd3);
        add_write(CFG_HOLD_TICKS, 16'hFFFF);
        add_write(CFG_EXT_SOUND, 16'd0);
        add_beat(4'b0010, 0, '0);
        add_beat(4'b0011, 0, '0);
        add_beat(4'b1101, 0, '0);
        add_beat(4'b1100, 0, '0);
        // back to normal mode with the break-in machine mid-way
        add_write(CFG_SEMI_BREAKIN, 16'd0);
        add_beat(4'b0010, 0, '0);
        add_beat(4'b1111, 0, '0);
        // no host line, hold of one tick
        add_write(CFG_HOST_SELECT, CFG_DATA_WIDTH'(HOST_NONE));
        add_write(CFG_HOLD_TICKS, 16'd1);
        add_write(CFG_SEMI_BREAKIN, 16'd1);
        add_beat(4'b1000, 0, '0);
        add_beat(4'b0011, 0, '0);
        add_beat(4'b1101, 0, '0);
        add_beat(4'b1101, 0, '0);
    endfunction

    // main sequence
    initial
    begin
        logic [CFG_DATA_WIDTH-1:0] hold_pick;
        clear_keyer();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        build_directed();
        foreach (poll_rows[i])
        begin
            if (poll_rows[i].is_write)
                write_reg(poll_rows[i].idx, poll_rows[i].data);
            else
                poll_and_check(poll_rows[i].beat, poll_rows[i].has_lit, poll_rows[i].lit);
        end

        // random phases, each with its own settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(9))
                0:       hold_pick = 16'd1;
                1:       hold_pick = 16'hFFFF;
                2:       hold_pick = CFG_DATA_WIDTH'($urandom_range(16'hFFFF));
                default: hold_pick = CFG_DATA_WIDTH'($urandom_range(6, 1));
            endcase
            write_reg(CFG_SEMI_BREAKIN, CFG_DATA_WIDTH'($urandom_range(99) < 70));
            write_reg(CFG_HOST_SELECT, CFG_DATA_WIDTH'($urandom_range(3)));
            write_reg(CFG_EXT_SOUND, CFG_DATA_WIDTH'($urandom_range(1)));
            write_reg(CFG_HOLD_TICKS, hold_pick);
            calm = (ph == 6 || ph == 7);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                // hold the sender until everything is back
                if (n == 20 && ph % 4 == 2)
                    drain_results();
                poll_and_check(random_beat(), 0, '0);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("cw_keying_semi_breakin_control_core_test passed");
        else
            $display("cw_keying_semi_breakin_control_core_test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/cwk_pkg.sv
rtl/cwk_cfg_regs.sv
rtl/cwk_ctrl.sv
rtl/cw_keying_semi_breakin_control_core.sv
test/cw_keying_semi_breakin_control_core_test.sv
